FILE: src/ftc_pkg.sv
// ----------------------------------------------------------------------------
// ftc_pkg
// Shared types and constants for the frame count to timecode converter.
// ----------------------------------------------------------------------------
package ftc_pkg;

   localparam int FRAME_BITS = 24;
   localparam int IN_W       = FRAME_BITS + 1;
   localparam int MAG_W      = 32;          // corrected count stays below 2^32
   localparam int DIVR_W     = 17;          // widest divisor register
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam int HOURS_W    = 14;
   localparam logic [HOURS_W-1:0] HOURS_MAX = 14'h3FFF;
   localparam logic [MAG_W-1:0]   SIXTY     = 32'd60;
   localparam logic [MAG_W-1:0]   RECIP15   = 32'h8888_8889;   // ceil(2^35 / 15)

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DROP_MODE   = 3'd0,
      CSR_TIMEBASE    = 3'd1,
      CSR_DROP_COUNT  = 3'd2,
      CSR_FRAMES_10M  = 3'd3,
      CSR_FRAMES_1M   = 3'd4
   } csr_index_type;

   // data that rides along with a beat through a divider
   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] val;
      logic [5:0]       sec;
      logic [6:0]       frame;
   } side_type;

endpackage

FILE: src/ftc_div.sv
// ----------------------------------------------------------------------------
// ftc_div
// Pipelined restoring divider: one quotient bit per stage, 32 stages.
// Also holds ftc_div60, a two-stage divide by sixty by reciprocal multiply.
// ----------------------------------------------------------------------------
module ftc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [ftc_pkg::MAG_W-1:0]   in_dividend,
   input  logic [ftc_pkg::DIVR_W-1:0]  in_divisor,
   input  ftc_pkg::side_type           in_side,
   output logic                        out_valid,
   output logic [ftc_pkg::MAG_W-1:0]   out_quotient,
   output logic [ftc_pkg::DIVR_W-1:0]  out_remainder,
   output ftc_pkg::side_type           out_side
);
   import ftc_pkg::*;

   // divisor is a config value; the user must hold it steady while beats are in flight, this block does not enforce it
   logic [MAG_W-1:0]  quo_ff  [MAG_W];
   logic [DIVR_W-1:0] rem_ff  [MAG_W];
   side_type          side_ff [MAG_W];
   logic [MAG_W-1:0]  vld_ff;

   genvar k;
   generate
      for (k = 0; k < MAG_W; k++) begin : g_stage
         logic [MAG_W-1:0]  quo_src;
         logic [DIVR_W-1:0] rem_src;
         side_type          side_src;
         logic              vld_src;
         logic [DIVR_W:0]   trial;
         logic              ge;
         logic [MAG_W-1:0]  quo_in;
         logic [DIVR_W-1:0] rem_in;

         if (k == 0) begin : g_first
            assign quo_src  = in_dividend;
            assign rem_src  = '0;
            assign side_src = in_side;
            assign vld_src  = in_valid;
         end else begin : g_next
            assign quo_src  = quo_ff[k-1];
            assign rem_src  = rem_ff[k-1];
            assign side_src = side_ff[k-1];
            assign vld_src  = vld_ff[k-1];
         end

         always_comb begin
            trial  = {rem_src, quo_src[MAG_W-1]};
            ge     = trial >= {1'b0, in_divisor};
            rem_in = ge ? DIVR_W'(trial - {1'b0, in_divisor}) : DIVR_W'(trial);
            quo_in = {quo_src[MAG_W-2:0], ge};
         end

         always_ff @(posedge clock) begin
            quo_ff[k]  <= quo_in;
            rem_ff[k]  <= rem_in;
            side_ff[k] <= side_src;
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else begin
               vld_ff[k] <= vld_src;
            end
         end
      end
   endgenerate

   assign out_valid     = vld_ff[MAG_W-1];
   assign out_quotient  = quo_ff[MAG_W-1];
   assign out_remainder = rem_ff[MAG_W-1];
   assign out_side      = side_ff[MAG_W-1];

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_remainder < in_divisor)
      else $error("remainder not below divisor");

   a_first_stage_fits: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |-> rem_ff[0] < in_divisor)
      else $error("first stage remainder out of range");

   a_valid_flows: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |=> vld_ff[1])
      else $error("valid lost between stages");

endmodule

module ftc_div60 (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [ftc_pkg::MAG_W-1:0]   in_dividend,
   input  ftc_pkg::side_type           in_side,
   output logic                        out_valid,
   output logic [ftc_pkg::MAG_W-1:0]   out_quotient,
   output logic [5:0]                  out_remainder,
   output ftc_pkg::side_type           out_side
);
   import ftc_pkg::*;

   // x / 60 = (x >> 2) / 15, and y / 15 = (y * RECIP15) >> 35 for any 32-bit y
   logic [61:0]      prod;
   logic [MAG_W-1:0] quo_in;
   logic [MAG_W-1:0] num1_ff, quo1_ff;
   side_type         side1_ff;
   logic             vld1_ff;
   logic [MAG_W-1:0] rem_full;
   logic [MAG_W-1:0] quo2_ff;
   logic [5:0]       rem2_ff;
   side_type         side2_ff;
   logic             vld2_ff;

   assign prod   = 62'(in_dividend[MAG_W-1:2]) * 62'(RECIP15);
   assign quo_in = MAG_W'(prod[61:35]);

   always_ff @(posedge clock) begin
      num1_ff  <= in_dividend;
      quo1_ff  <= quo_in;
      side1_ff <= in_side;
      if (reset) begin
         vld1_ff <= 1'b0;
      end else begin
         vld1_ff <= in_valid;
      end
   end

   assign rem_full = num1_ff - MAG_W'(quo1_ff * SIXTY);

   always_ff @(posedge clock) begin
      quo2_ff  <= quo1_ff;
      rem2_ff  <= rem_full[5:0];
      side2_ff <= side1_ff;
      if (reset) begin
         vld2_ff <= 1'b0;
      end else begin
         vld2_ff <= vld1_ff;
      end
   end

   assign out_valid     = vld2_ff;
   assign out_quotient  = quo2_ff;
   assign out_remainder = rem2_ff;
   assign out_side      = side2_ff;

   a_quotient_exact: assert property (@(posedge clock) disable iff (reset)
      vld1_ff |-> rem_full < SIXTY)
      else $error("divide by sixty quotient off");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_remainder < 6'd60)
      else $error("divide by sixty remainder out of range");

   a_valid_flows: assert property (@(posedge clock) disable iff (reset)
      vld1_ff |=> vld2_ff)
      else $error("valid lost in divide by sixty");

endmodule

FILE: src/frame_count_to_timecode.sv
// ----------------------------------------------------------------------------
// frame_count_to_timecode
// Signed frame count to hours/minutes/seconds/frames, with drop-frame fix.
// ----------------------------------------------------------------------------
// Fully pipelined: one frame count may be started every cycle and busy never
// rises. The path is 104 register stages deep: three 32-stage bit-per-cycle
// dividers (ten minute split, minute split, timebase), two 2-stage divide by
// sixty units and four more register stages. The edge that accepts start
// loads the first stage, and rsp_strobe is high for one cycle once the beat
// reaches the output register. Results cannot be held off. Write configuration
// only while no beat is in flight. A zero divisor register behaves as one.
module frame_count_to_timecode (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic signed [ftc_pkg::IN_W-1:0]  req_frame_number,
   output logic                             rsp_strobe,
   output logic                             rsp_negative,
   output logic [ftc_pkg::HOURS_W-1:0]      rsp_hours,
   output logic [5:0]                       rsp_minutes,
   output logic [5:0]                       rsp_seconds,
   output logic [6:0]                       rsp_frame_in_second,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ftc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ftc_pkg::CSR_DATA_W-1:0]   csr_data
);
   import ftc_pkg::*;

   // configuration
   logic        drop_mode_ff;
   logic [6:0]  timebase_ff;
   logic [3:0]  drop_count_ff;
   logic [16:0] f10_ff;
   logic [12:0] fpm_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         drop_mode_ff  <= 1'b1;
         timebase_ff   <= 7'd30;
         drop_count_ff <= 4'd2;
         f10_ff        <= 17'd17982;
         fpm_ff        <= 13'd1798;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_DROP_MODE:  drop_mode_ff  <= csr_data[0];
            CSR_TIMEBASE:   timebase_ff   <= csr_data[6:0];
            CSR_DROP_COUNT: drop_count_ff <= csr_data[3:0];
            CSR_FRAMES_10M: f10_ff        <= csr_data[16:0];
            CSR_FRAMES_1M:  fpm_ff        <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   logic [DIVR_W-1:0] tb_eff, f10_eff, fpm_eff;
   assign tb_eff  = (timebase_ff == '0) ? DIVR_W'(1) : DIVR_W'(timebase_ff);
   assign f10_eff = (f10_ff == '0)      ? DIVR_W'(1) : f10_ff;
   assign fpm_eff = (fpm_ff == '0)      ? DIVR_W'(1) : DIVR_W'(fpm_ff);

   // stage 0: magnitude
   logic             s0_vld_ff;
   side_type         s0_ff;
   logic [IN_W-1:0]  mag_in;

   assign mag_in = req_frame_number[IN_W-1] ? IN_W'(-req_frame_number)
                                            : IN_W'(req_frame_number);

   always_ff @(posedge clock) begin
      s0_ff.neg   <= req_frame_number[IN_W-1];
      s0_ff.val   <= MAG_W'(mag_in);
      s0_ff.sec   <= '0;
      s0_ff.frame <= '0;
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= start && !busy;
      end
   end

   // divider A: magnitude over frames per ten minutes
   logic              a_vld;
   logic [MAG_W-1:0]  a_quo;
   logic [DIVR_W-1:0] a_rem;
   side_type          a_side;

   ftc_div u_div_ten (
      .clock, .reset,
      .in_valid(s0_vld_ff), .in_dividend(s0_ff.val), .in_divisor(f10_eff),
      .in_side(s0_ff),
      .out_valid(a_vld), .out_quotient(a_quo), .out_remainder(a_rem),
      .out_side(a_side)
   );

   // stage 1: in drop mode, add dc*9 per ten-minute block and set up minute numerator
   logic             s1_vld_ff;
   side_type         s1_ff, s1_in;
   logic [MAG_W-1:0] s1_num_ff, s1_num_in;
   logic [7:0]       dc9;

   assign dc9 = 8'(drop_count_ff) * 8'd9;

   always_comb begin
      s1_in     = a_side;
      s1_num_in = '0;
      if (drop_mode_ff) begin
         s1_in.val = a_side.val + MAG_W'(dc9) * MAG_W'(a_quo[IN_W-1:0]);
         if (a_rem > DIVR_W'(drop_count_ff)) begin
            s1_num_in = MAG_W'(a_rem - DIVR_W'(drop_count_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_ff     <= s1_in;
      s1_num_ff <= s1_num_in;
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= a_vld;
      end
   end

   // divider B: minutes within block
   logic              b_vld;
   logic [MAG_W-1:0]  b_quo;
   logic [DIVR_W-1:0] b_rem;
   side_type          b_side;

   ftc_div u_div_min (
      .clock, .reset,
      .in_valid(s1_vld_ff), .in_dividend(s1_num_ff), .in_divisor(fpm_eff),
      .in_side(s1_ff),
      .out_valid(b_vld), .out_quotient(b_quo), .out_remainder(b_rem),
      .out_side(b_side)
   );

   // stage 2: corrected count
   logic     s2_vld_ff;
   side_type s2_ff, s2_in;

   always_comb begin
      s2_in     = b_side;
      s2_in.val = b_side.val + MAG_W'(drop_count_ff) * MAG_W'(b_quo[DIVR_W-1:0]);
   end

   always_ff @(posedge clock) begin
      s2_ff <= s2_in;
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= b_vld;
      end
   end

   // divider C: split by timebase
   logic              c_vld;
   logic [MAG_W-1:0]  c_quo;
   logic [DIVR_W-1:0] c_rem;
   side_type          c_side, c_side_in;

   ftc_div u_div_tb (
      .clock, .reset,
      .in_valid(s2_vld_ff), .in_dividend(s2_ff.val), .in_divisor(tb_eff),
      .in_side(s2_ff),
      .out_valid(c_vld), .out_quotient(c_quo), .out_remainder(c_rem),
      .out_side(c_side)
   );

   always_comb begin
      c_side_in       = c_side;
      c_side_in.frame = c_rem[6:0];
   end

   // divide by sixty: seconds
   logic              d_vld;
   logic [MAG_W-1:0]  d_quo;
   logic [5:0]        d_rem;
   side_type          d_side, d_side_in;

   ftc_div60 u_div_sec (
      .clock, .reset,
      .in_valid(c_vld), .in_dividend(c_quo), .in_side(c_side_in),
      .out_valid(d_vld), .out_quotient(d_quo), .out_remainder(d_rem),
      .out_side(d_side)
   );

   always_comb begin
      d_side_in     = d_side;
      d_side_in.sec = d_rem;
   end

   // divide by sixty: minutes and hours
   logic              e_vld;
   logic [MAG_W-1:0]  e_quo;
   logic [5:0]        e_rem;
   side_type          e_side;

   ftc_div60 u_div_hr (
      .clock, .reset,
      .in_valid(d_vld), .in_dividend(d_quo), .in_side(d_side_in),
      .out_valid(e_vld), .out_quotient(e_quo), .out_remainder(e_rem),
      .out_side(e_side)
   );

   // output register, hours saturate
   always_ff @(posedge clock) begin
      rsp_negative        <= e_side.neg;
      rsp_hours           <= (e_quo > MAG_W'(HOURS_MAX)) ? HOURS_MAX
                                                         : e_quo[HOURS_W-1:0];
      rsp_minutes         <= e_rem;
      rsp_seconds         <= e_side.sec;
      rsp_frame_in_second <= e_side.frame;
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= e_vld;
      end
   end

   a_minutes_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_minutes < 6'd60)
      else $error("minutes out of range");

   a_seconds_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_seconds < 6'd60)
      else $error("seconds out of range");

   a_frame_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> DIVR_W'(rsp_frame_in_second) < tb_eff)
      else $error("frame label not below timebase");

endmodule

FILE: dv/frame_count_to_timecode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_count_to_timecode_checker
// Watches the command, result and register channels of the converter,
// predicts each timecode from the register shadow and compares it per field.
// ----------------------------------------------------------------------------
module frame_count_to_timecode_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic signed [ftc_pkg::IN_W-1:0]  req_frame_number,
   input  logic                             rsp_strobe,
   input  logic                             rsp_negative,
   input  logic [ftc_pkg::HOURS_W-1:0]      rsp_hours,
   input  logic [5:0]                       rsp_minutes,
   input  logic [5:0]                       rsp_seconds,
   input  logic [6:0]                       rsp_frame_in_second,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [ftc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ftc_pkg::CSR_DATA_W-1:0]   csr_data,
   output int                               error_count,
   output int                               pending_count
);
   import ftc_pkg::*;

   typedef struct packed {
      logic             neg;
      logic [13:0]      hours;
      logic [5:0]       minutes;
      logic [5:0]       seconds;
      logic [6:0]       frame;
   } timecode_type;

   logic        drop_mode;
   logic [6:0]  timebase;
   logic [3:0]  drop_count;
   logic [16:0] frames_10m;
   logic [12:0] frames_1m;

   timecode_type expected_codes[$];

   function automatic timecode_type to_timecode(logic [IN_W-1:0] raw);
      timecode_type tc;
      logic [63:0] mag, tb, f10, fpm, dc, blocks, rem, tsec, tmin, hrs;
      tc.neg = raw[FRAME_BITS];
      mag = tc.neg ? 64'((~raw + 1'b1) & {IN_W{1'b1}}) : 64'(raw);
      tb  = (timebase == 0) ? 64'd1 : 64'(timebase);
      if (drop_mode) begin
         f10 = (frames_10m == 0) ? 64'd1 : 64'(frames_10m);
         fpm = (frames_1m == 0) ? 64'd1 : 64'(frames_1m);
         dc  = 64'(drop_count);
         blocks = mag / f10;
         rem    = mag % f10;
         mag = mag + dc * 9 * blocks;
         if (rem > dc) begin
            mag = mag + dc * ((rem - dc) / fpm);
         end
      end
      tsec = mag / tb;
      tmin = tsec / 60;
      hrs  = tmin / 60;
      tc.hours   = (hrs > 64'(HOURS_MAX)) ? HOURS_MAX : hrs[13:0];
      tc.minutes = 6'(tmin % 60);
      tc.seconds = 6'(tsec % 60);
      tc.frame   = 7'(mag % tb);
      return tc;
   endfunction

   always @(posedge clock) begin
      timecode_type want;
      if (reset) begin
         drop_mode  <= 1'b1;
         timebase   <= 7'd30;
         drop_count <= 4'd2;
         frames_10m <= 17'd17982;
         frames_1m  <= 13'd1798;
         expected_codes.delete();
         error_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DROP_MODE:  drop_mode  <= csr_data[0];
               CSR_TIMEBASE:   timebase   <= csr_data[6:0];
               CSR_DROP_COUNT: drop_count <= csr_data[3:0];
               CSR_FRAMES_10M: frames_10m <= csr_data[16:0];
               CSR_FRAMES_1M:  frames_1m  <= csr_data[12:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            expected_codes.push_back(to_timecode(req_frame_number));
         end
         if (rsp_strobe) begin
            if (expected_codes.size() == 0) begin
               $error("unexpected result beat");
               error_count <= error_count + 1;
            end else begin
               want = expected_codes.pop_front();
               if (rsp_negative !== want.neg ||
                   rsp_hours !== want.hours ||
                   rsp_minutes !== want.minutes ||
                   rsp_seconds !== want.seconds ||
                   rsp_frame_in_second !== want.frame) begin
                  error_count <= error_count + 1;
                  if (rsp_negative !== want.neg)
                     $error("negative: expected %0d got %0d", want.neg, rsp_negative);
                  if (rsp_hours !== want.hours)
                     $error("hours: expected %0d got %0d", want.hours, rsp_hours);
                  if (rsp_minutes !== want.minutes)
                     $error("minutes: expected %0d got %0d", want.minutes, rsp_minutes);
                  if (rsp_seconds !== want.seconds)
                     $error("seconds: expected %0d got %0d", want.seconds, rsp_seconds);
                  if (rsp_frame_in_second !== want.frame)
                     $error("frame_in_second: expected %0d got %0d",
                            want.frame, rsp_frame_in_second);
               end
            end
         end
      end
   end

   assign pending_count = expected_codes.size();

endmodule

FILE: dv/tb_frame_count_to_timecode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_count_to_timecode
// Drives frame counts and register settings into the converter; the checker
// beside it predicts and compares every timecode.
// ----------------------------------------------------------------------------
module tb_frame_count_to_timecode;
   import ftc_pkg::*;

   localparam int DRAIN_CYCLES = 200;
   localparam logic [IN_W-1:0] MOST_NEG = {1'b1, {FRAME_BITS{1'b0}}};

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic signed [IN_W-1:0]  req_frame_number = '0;
   logic                    rsp_strobe;
   logic                    rsp_negative;
   logic [HOURS_W-1:0]      rsp_hours;
   logic [5:0]              rsp_minutes;
   logic [5:0]              rsp_seconds;
   logic [6:0]              rsp_frame_in_second;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = CSR_DROP_MODE;
   logic [CSR_DATA_W-1:0]   csr_data = '0;
   int                      error_count;
   int                      pending_count;
   bit                      allow_idle = 1'b1;

   always #5 clock = ~clock;

   frame_count_to_timecode i_dut (.*);

   frame_count_to_timecode_checker i_checker (.*);

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // waits for every outstanding timecode, then lets the pipeline settle
   task automatic drain();
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_frame(logic [IN_W-1:0] value);
      int gap;
      if (allow_idle && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 18);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_frame_number <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic apply_setting(logic dm, logic [6:0] tb, logic [3:0] dc,
                                logic [16:0] f10, logic [12:0] f1);
      write_reg(CSR_DROP_MODE, CSR_DATA_W'(dm));
      write_reg(CSR_TIMEBASE, CSR_DATA_W'(tb));
      write_reg(CSR_DROP_COUNT, CSR_DATA_W'(dc));
      write_reg(CSR_FRAMES_10M, CSR_DATA_W'(f10));
      write_reg(CSR_FRAMES_1M, CSR_DATA_W'(f1));
   endtask

   function automatic logic [IN_W-1:0] rand_frame();
      logic [IN_W-1:0] v;
      case ($urandom_range(0, 5))
         0: v = IN_W'($urandom_range(0, 200000));
         1: v = -IN_W'($urandom_range(0, 200000));
         2: v = MOST_NEG;
         default: v = IN_W'($urandom());
      endcase
      return v;
   endfunction

   task automatic random_phase(int count);
      repeat (count) send_frame(rand_frame());
      start <= 1'b0;
      drain();
   endtask

   initial begin
      logic [IN_W-1:0] directed[$];
      logic [6:0] tb;
      logic [3:0] dc;
      directed = '{'0, IN_W'(1), IN_W'(17981), IN_W'(17982), IN_W'(1799),
                   IN_W'(1800), IN_W'(107892), IN_W'(24'hFFFFFF), -IN_W'(1),
                   -IN_W'(24'hFFFFFF), MOST_NEG, IN_W'(2), IN_W'(3), IN_W'(5395),
                   {1'b0, 24'h555555}, {1'b1, 24'hAAAAAA}};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[k]) send_frame(directed[k]);
      start <= 1'b0;
      drain();

      // non-drop at timebase 1, then zero divisors with the widest drop
      // count, where large counts saturate hours
      apply_setting(1'b0, 7'd1, 4'd0, 17'd1, 13'd1);
      foreach (directed[k]) send_frame(directed[k]);
      start <= 1'b0;
      drain();
      apply_setting(1'b1, 7'd0, 4'd15, 17'd0, 13'd0);
      random_phase(60);
      apply_setting(1'b1, 7'd127, 4'd8, 17'h1FFFF, 13'h1FFF);
      random_phase(60);
      apply_setting(1'b1, 7'd60, 4'd4, 17'd35964, 13'd3596);
      random_phase(150);
      apply_setting(1'b0, 7'd120, 4'd0, 17'd72000, 13'd7200);
      random_phase(150);
      apply_setting(1'b0, 7'd25, 4'd0, 17'd15000, 13'd1500);
      random_phase(150);

      repeat (8) begin
         tb = 7'($urandom_range(1, 120));
         dc = 4'($urandom_range(0, 8));
         apply_setting(1'($urandom()), tb, dc, 17'(tb * 600 - dc * 9),
                       13'(tb * 60 - dc));
         random_phase(120);
      end

      apply_setting(1'b1, 7'd30, 4'd2, 17'd17982, 13'd1798);
      random_phase(100);
      allow_idle = 1'b0;
      random_phase(100);

      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
